FILE: design/rpcc_pkg.sv
package rpcc_pkg;

    localparam int REGIONS_DEF       = 16;
    localparam int CACHE_ENTRIES_DEF = 64;
    localparam int CLUSTER_SHIFT_DEF = 23;

    localparam int OFFSET_W  = 48;
    localparam int SIZE_W    = 32;
    localparam int TAG_W     = 32;
    localparam int COUNT_W   = 7;

    typedef enum logic [2:0] {
        OP_LOCK   = 3'd0,
        OP_UNLOCK = 3'd1,
        OP_CANCEL = 3'd2,
        OP_TICK   = 3'd3,
        OP_GET    = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_RSVD6  = 3'd6,
        OP_RSVD7  = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NO_FREE  = 3'd1,
        STS_BAD_SIZE = 3'd2,
        STS_NONE     = 3'd3,
        STS_CONFLICT = 3'd4,
        STS_NOT_LOCK = 3'd5,
        STS_BUSY     = 3'd6,
        STS_FREE     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        RS_FREE    = 2'd0,
        RS_ALLOC   = 2'd1,
        RS_LOCKING = 2'd2,
        RS_LOCKED  = 2'd3
    } region_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_TICK_RD,
        S_TICK_MOD,
        S_TICK_CHK,
        S_TICK_END,
        S_GET_RD,
        S_GET_MOD,
        S_DONE
    } ctrl_state_t;

endpackage

FILE: design/region_pin_cluster_cache_top.sv
// Region-pinning controller for a direct-mapped cluster cache. start is taken while busy is
// low; each command gives exactly one result with done high for one cycle, and the receiver
// cannot stall it. Lock, unknown opcodes and commands that end at once with an error status
// go straight to the result state; unlock, cancel-all and clear-cache sweep every cache entry
// one per cycle; get-data runs a 32-step serial modulo by entry_count, a tick runs the same
// modulo for its cluster, and a tick that pins a region's last cluster runs it a second
// time for the region's start entry. Entry tags and pin masks live in one synchronous RAM,
// read, modified and written back one entry at a time. After reset the block sweeps the
// cache RAM clean, with busy high, before the first command is taken.
module region_pin_cluster_cache_top
    import rpcc_pkg::*;
#(
    parameter int REGIONS       = REGIONS_DEF,
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int CLUSTER_SHIFT = CLUSTER_SHIFT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    opcode,
    input  logic [47:0]   byte_offset,
    input  logic [31:0]   byte_size,
    input  logic [3:0]    region_id,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_wdata,
    output logic          done,
    output logic [2:0]    status,
    output logic [3:0]    region_out,
    output logic          fill_request,
    output logic [25:0]   fill_cluster,
    output logic [5:0]    fill_entry,
    output logic [28:0]   data_address,
    output logic          region_locked,
    output logic [5:0]    wrap_clusters,
    output logic [4:0]    pending_count
);

    localparam int RID_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int QCNT_W = $clog2(REGIONS + 1);
    localparam int EID_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int LINE_W = 1 + TAG_W + REGIONS;
    localparam int SPAN_W = OFFSET_W - CLUSTER_SHIFT + 1;

    // configuration
    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] ec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_W'(64);
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (entry_count_reg == '0)
            ec = COUNT_W'(1);
        else if (32'(entry_count_reg) > CACHE_ENTRIES)
            ec = COUNT_W'(CACHE_ENTRIES);
        else
            ec = entry_count_reg;
    end

    // region table, queue
    region_state_t         rstat_reg [REGIONS];
    region_state_t         rstat_next [REGIONS];
    logic [OFFSET_W-1:0]   rstart_reg [REGIONS];
    logic [SIZE_W-1:0]     rlen_reg [REGIONS];
    logic [COUNT_W-1:0]    rprog_reg [REGIONS];
    logic [RID_W-1:0]      queue_reg [REGIONS];
    logic [RID_W-1:0]      queue_next [REGIONS];
    logic [QCNT_W-1:0]     qcnt_reg, qcnt_next;

    // command latch
    ctrl_state_t           state_reg, state_next;
    opcode_t               op_reg;
    logic [3:0]            id_reg;
    logic [RID_W-1:0]      h_reg, h_next;
    logic [EID_W-1:0]      idx_reg, idx_next;
    logic [TAG_W-1:0]      cl_reg, cl_next;
    logic [COUNT_W-1:0]    e_reg, e_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic                  init_reg, init_next;

    // result registers
    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic [3:0]            rout_reg, rout_next;
    logic                  freq_reg, freq_next;
    logic [25:0]           fcl_reg, fcl_next;
    logic [5:0]            fent_reg, fent_next;
    logic [28:0]           daddr_reg, daddr_next;
    logic                  rlock_reg, rlock_next;
    logic [5:0]            wrap_reg, wrap_next;

    // cache line memory
    logic                  mem_we;
    logic [EID_W-1:0]      mem_waddr, mem_raddr;
    logic [LINE_W-1:0]     mem_wdata, mem_rdata;
    logic                  line_valid;
    logic [TAG_W-1:0]      line_tag;
    logic [REGIONS-1:0]    line_pins;

    rpcc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign line_valid = mem_rdata[LINE_W-1];
    assign line_tag   = mem_rdata[LINE_W-2 -: TAG_W];
    assign line_pins  = mem_rdata[REGIONS-1:0];

    // modulo unit
    logic               mod_go;
    logic [TAG_W-1:0]   mod_num;
    logic               mod_done;
    logic [COUNT_W-1:0] mod_rem;

    rpcc_modu u_modu (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (mod_num),
        .divisor   (ec),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // lock-side span
    logic [OFFSET_W:0]   lk_end;
    logic [SPAN_W-1:0]   lk_span;
    logic [RID_W-1:0]    free_slot;
    logic                free_found;
    // tick-side values
    logic [OFFSET_W-1:0] h_start;
    logic [OFFSET_W:0]   h_end;
    logic [SPAN_W-1:0]   h_span;
    logic [TAG_W-1:0]    h_beg;
    logic [SPAN_W:0]     wrap_sum;
    logic [QCNT_W-1:0]   keep_n;
    logic                accept;

    assign accept = start && !busy;

    always_comb
    begin
        lk_end  = ({1'b0, byte_offset} + (OFFSET_W+1)'(byte_size)
                   + (OFFSET_W+1)'((64'd1 << CLUSTER_SHIFT) - 1)) >> CLUSTER_SHIFT;
        lk_span = SPAN_W'(lk_end - (OFFSET_W+1)'(byte_offset >> CLUSTER_SHIFT));
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = REGIONS - 1; i >= 0; i--)
        begin
            if (rstat_reg[i] == RS_FREE)
            begin
                free_found = 1'b1;
                free_slot  = RID_W'(i);
            end
        end
        h_start = rstart_reg[h_reg];
        h_end   = ({1'b0, h_start} + (OFFSET_W+1)'(rlen_reg[h_reg])
                   + (OFFSET_W+1)'((64'd1 << CLUSTER_SHIFT) - 1)) >> CLUSTER_SHIFT;
        h_span  = SPAN_W'(h_end - (OFFSET_W+1)'(h_start >> CLUSTER_SHIFT));
        h_beg   = TAG_W'(h_start >> CLUSTER_SHIFT);
    end

    // control
    always_comb
    begin
        state_next  = state_reg;
        rstat_next  = rstat_reg;
        queue_next  = queue_reg;
        qcnt_next   = qcnt_reg;
        h_next      = h_reg;
        idx_next    = idx_reg;
        cl_next     = cl_reg;
        e_next      = e_reg;
        span_next   = span_reg;
        init_next   = init_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rout_next   = rout_reg;
        freq_next   = freq_reg;
        fcl_next    = fcl_reg;
        fent_next   = fent_reg;
        daddr_next  = daddr_reg;
        rlock_next  = rlock_reg;
        wrap_next   = wrap_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;
        mem_raddr   = idx_reg;
        mod_go      = 1'b0;
        mod_num     = '0;
        wrap_sum    = '0;
        keep_n      = '0;
        busy        = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                // entry 0 is read ahead so a sweep starts with its line
                mem_raddr = '0;
                if (accept)
                begin
                    status_next = STS_OK;
                    rout_next   = '0;
                    freq_next   = 1'b0;
                    fcl_next    = '0;
                    fent_next   = '0;
                    daddr_next  = '0;
                    rlock_next  = 1'b0;
                    wrap_next   = '0;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    unique case (opcode_t'(opcode))
                        OP_LOCK:
                        begin
                            if (lk_span == '0 || lk_span > SPAN_W'(ec))
                                status_next = STS_BAD_SIZE;
                            else if (!free_found || qcnt_reg >= QCNT_W'(REGIONS))
                                status_next = STS_NO_FREE;
                            else
                            begin
                                rstat_next[free_slot] = RS_ALLOC;
                                queue_next[qcnt_reg[RID_W-1:0]] = free_slot;
                                qcnt_next = qcnt_reg + 1'b1;
                                rout_next = 4'(free_slot);
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (32'(region_id) >= REGIONS
                                || rstat_reg[RID_W'(region_id)] == RS_FREE)
                                status_next = STS_FREE;
                            else
                            begin
                                // drop from queue keeping order
                                for (int i = 0; i < REGIONS; i++)
                                begin
                                    if (QCNT_W'(i) < qcnt_reg
                                        && queue_reg[i] != RID_W'(region_id))
                                    begin
                                        queue_next[keep_n[RID_W-1:0]] = queue_reg[i];
                                        keep_n = keep_n + 1'b1;
                                    end
                                end
                                qcnt_next = keep_n;
                                rstat_next[RID_W'(region_id)] = RS_FREE;
                                rout_next  = region_id;
                                state_next = S_SWEEP;
                            end
                        end
                        OP_CANCEL:
                        begin
                            qcnt_next = '0;
                            for (int i = 0; i < REGIONS; i++)
                                rstat_next[i] = RS_FREE;
                            state_next = S_SWEEP;
                        end
                        OP_TICK:
                        begin
                            if (qcnt_reg == '0)
                                status_next = STS_NONE;
                            else
                            begin
                                h_next     = queue_reg[0];
                                rout_next  = 4'(queue_reg[0]);
                                state_next = S_TICK_RD;
                            end
                        end
                        OP_GET:
                        begin
                            if (32'(region_id) >= REGIONS
                                || rstat_reg[RID_W'(region_id)] == RS_FREE)
                                status_next = STS_FREE;
                            else if (rstat_reg[RID_W'(region_id)] != RS_LOCKED)
                            begin
                                status_next = STS_NOT_LOCK;
                                rout_next   = region_id;
                            end
                            else
                            begin
                                h_next     = RID_W'(region_id);
                                rout_next  = region_id;
                                state_next = S_GET_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (qcnt_reg != '0)
                                status_next = STS_BUSY;
                            else
                                state_next = S_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // one entry per cycle; unlock keeps tags and clears one pin bit
                mem_raddr = idx_reg + 1'b1;
                mem_we    = 1'b1;
                if (!init_reg && op_reg == OP_UNLOCK)
                    mem_wdata = {line_valid, line_tag,
                                 line_pins & ~(REGIONS'(1) << RID_W'(id_reg))};
                else
                    mem_wdata = {1'b0, {TAG_W{1'b1}}, {REGIONS{1'b0}}};
                if (32'(idx_reg) == CACHE_ENTRIES - 1)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_TICK_RD:
            begin
                cl_next = h_beg + TAG_W'(rprog_reg[h_reg]);
                span_next = h_span;
                if (rstat_reg[h_reg] == RS_ALLOC)
                    rstat_next[h_reg] = RS_LOCKING;
                mod_go     = 1'b1;
                mod_num    = h_beg + TAG_W'(rprog_reg[h_reg]);
                state_next = S_TICK_MOD;
            end
            S_TICK_MOD:
            begin
                if (mod_done)
                begin
                    e_next     = mod_rem;
                    idx_next   = EID_W'(mod_rem);
                    mem_raddr  = EID_W'(mod_rem);
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_CHK:
            begin
                mem_waddr = idx_reg;
                if (!line_valid || line_tag != cl_reg)
                begin
                    if (line_pins != '0)
                    begin
                        status_next = STS_CONFLICT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        freq_next = 1'b1;
                        fcl_next  = cl_reg[25:0];
                        fent_next = 6'(e_reg);
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, cl_reg, REGIONS'(1) << h_reg};
                        state_next = S_TICK_END;
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, line_tag, line_pins | (REGIONS'(1) << h_reg)};
                    state_next = S_TICK_END;
                end
                if (state_next == S_TICK_END
                    && SPAN_W'(rprog_reg[h_reg]) + 1'b1 >= span_reg)
                begin
                    // last cluster: need start entry for wrap count
                    mod_go  = 1'b1;
                    mod_num = h_beg;
                end
            end
            S_TICK_END:
            begin
                if (SPAN_W'(rprog_reg[h_reg]) < span_reg)
                    state_next = S_DONE;
                else if (mod_done)
                begin
                    wrap_sum = (SPAN_W+1)'(mod_rem) + (SPAN_W+1)'(span_reg);
                    if (wrap_sum > (SPAN_W+1)'(ec))
                        wrap_next = 6'(wrap_sum - (SPAN_W+1)'(ec));
                    rlock_next = 1'b1;
                    rstat_next[h_reg] = RS_LOCKED;
                    for (int i = 0; i < REGIONS - 1; i++)
                        queue_next[i] = queue_reg[i+1];
                    qcnt_next  = qcnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_GET_RD:
            begin
                mod_go     = 1'b1;
                mod_num    = h_beg;
                state_next = S_GET_MOD;
            end
            S_GET_MOD:
            begin
                if (mod_done)
                begin
                    daddr_next = 29'(({(OFFSET_W)'(mod_rem)} << CLUSTER_SHIFT)
                                 + (h_start & ((OFFSET_W'(1) << CLUSTER_SHIFT) - 1'b1)));
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            init_reg  <= 1'b1;
            idx_reg   <= '0;
            qcnt_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < REGIONS; i++)
                rstat_reg[i] <= RS_FREE;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            idx_reg   <= idx_next;
            qcnt_reg  <= qcnt_next;
            done_reg  <= done_next;
            rstat_reg <= rstat_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        queue_reg  <= queue_next;
        h_reg      <= h_next;
        cl_reg     <= cl_next;
        e_reg      <= e_next;
        span_reg   <= span_next;
        status_reg <= status_next;
        rout_reg   <= rout_next;
        freq_reg   <= freq_next;
        fcl_reg    <= fcl_next;
        fent_reg   <= fent_next;
        daddr_reg  <= daddr_next;
        rlock_reg  <= rlock_next;
        wrap_reg   <= wrap_next;
        if (accept)
        begin
            op_reg   <= opcode_t'(opcode);
            id_reg   <= region_id;
            if (opcode_t'(opcode) == OP_LOCK && status_next == STS_OK)
            begin
                rstart_reg[free_slot] <= byte_offset;
                rlen_reg[free_slot]   <= byte_size;
                rprog_reg[free_slot]  <= '0;
            end
        end
        if (state_reg == S_TICK_CHK && state_next == S_TICK_END)
            rprog_reg[h_reg] <= rprog_reg[h_reg] + 1'b1;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign region_out    = rout_reg;
    assign fill_request  = freq_reg;
    assign fill_cluster  = fcl_reg;
    assign fill_entry    = fent_reg;
    assign data_address  = daddr_reg;
    assign region_locked = rlock_reg;
    assign wrap_clusters = wrap_reg;
    assign pending_count = 5'(qcnt_reg);

endmodule

FILE: design/rpcc_ram.sv
module rpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/rpcc_modu.sv
module rpcc_modu
    import rpcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [TAG_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [COUNT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(TAG_W + 1);

    logic [COUNT_W:0]   rem_reg, rem_next;
    logic [TAG_W-1:0]   num_reg, num_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;

    // restoring remainder, one bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[COUNT_W-1:0], num_reg[TAG_W-1]};
        if (go)
        begin
            rem_next = '0;
            num_next = dividend;
            cnt_next = STEP_W'(TAG_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
            num_next = {num_reg[TAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[COUNT_W-1:0];

endmodule

FILE: design/rpcc_checker.sv
module rpcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic        fill_request,
    input logic        region_locked,
    input logic [5:0]  wrap_clusters,
    input logic [4:0]  pending_count
);

    // a result ends the command, so the block is free while done is high
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy after result");

    // an accepted command makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after transfer");

    // a fill only goes with an ok status
    a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fill_request) |-> status == 3'd0)
        else $error("fill with error status");

    // wrap count only reported with a completed lock
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !region_locked) |-> wrap_clusters == 6'd0)
        else $error("wrap without lock");

    // queue never exceeds sixteen regions
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pending_count <= 5'd16)
        else $error("queue overflow");

endmodule

bind region_pin_cluster_cache_top rpcc_checker u_rpcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .fill_request  (fill_request),
    .region_locked (region_locked),
    .wrap_clusters (wrap_clusters),
    .pending_count (pending_count)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rpcc_pkg::*;

    // one result as it appears on the result ports
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  region;
        logic        fill;
        logic [25:0] fill_cl;
        logic [5:0]  fill_ent;
        logic [28:0] addr;
        logic        locked;
        logic [5:0]  wrap;
        logic [4:0]  pend;
    } cache_result_t;

    // row of the directed table
    typedef struct {
        opcode_t     op;
        logic [47:0] off;
        logic [31:0] size;
        logic [3:0]  id;
        bit          typed;
        status_t     st;
        logic [4:0]  pend;
    } cmd_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [47:0] byte_offset;
    logic [31:0] byte_size;
    logic [3:0]  region_id;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  region_out;
    logic        fill_request;
    logic [25:0] fill_cluster;
    logic [5:0]  fill_entry;
    logic [28:0] data_address;
    logic        region_locked;
    logic [5:0]  wrap_clusters;
    logic [4:0]  pending_count;

    region_pin_cluster_cache_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .byte_offset(byte_offset), .byte_size(byte_size),
        .region_id(region_id), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .status(status), .region_out(region_out),
        .fill_request(fill_request), .fill_cluster(fill_cluster),
        .fill_entry(fill_entry), .data_address(data_address),
        .region_locked(region_locked), .wrap_clusters(wrap_clusters),
        .pending_count(pending_count)
    );

    // shadow copy of the controller state
    logic [6:0]    entries_reg;
    region_state_t slot_state [16];
    logic [47:0]   slot_start [16];
    logic [31:0]   slot_len [16];
    int unsigned   slot_done [16];
    logic [31:0]   tag_mem [64];
    bit            tag_ok [64];
    logic [15:0]   pin_mem [64];
    int            lock_order [$];

    cache_result_t pending_results [$];
    int            mismatches;
    bit            gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned entries_in_use();
        if (entries_reg == 0) return 1;
        if (entries_reg > 64) return 64;
        return entries_reg;
    endfunction

    function automatic longint unsigned cluster_span(logic [47:0] off, logic [31:0] size);
        longint unsigned last;
        last = (longint'(off) + longint'(size) + 64'h7F_FFFF) >> 23;
        return last - (longint'(off) >> 23);
    endfunction

    function automatic void empty_cache();
        for (int i = 0; i < 64; i++)
        begin
            tag_ok[i] = 1'b0;
            tag_mem[i] = '1;
            pin_mem[i] = '0;
        end
    endfunction

    // work out the result of one command and update the shadow state
    function automatic cache_result_t predict_command(opcode_t op, logic [47:0] off,
                                                      logic [31:0] size, logic [3:0] id);
        cache_result_t r;
        int unsigned ec;
        longint unsigned span, beg, b;
        int slot, h;
        logic [31:0] cl;
        int unsigned e;
        r = '0;
        ec = entries_in_use();
        case (op)
            OP_LOCK:
            begin
                span = cluster_span(off, size);
                if (span == 0 || span > ec)
                    r.status = STS_BAD_SIZE;
                else
                begin
                    slot = -1;
                    for (int i = 15; i >= 0; i--)
                        if (slot_state[i] == RS_FREE) slot = i;
                    if (slot < 0 || lock_order.size() >= 16)
                        r.status = STS_NO_FREE;
                    else
                    begin
                        slot_start[slot] = off;
                        slot_len[slot] = size;
                        slot_done[slot] = 0;
                        slot_state[slot] = RS_ALLOC;
                        lock_order.push_back(slot);
                        r.region = 4'(slot);
                    end
                end
            end
            OP_UNLOCK:
            begin
                if (slot_state[id] == RS_FREE)
                    r.status = STS_FREE;
                else
                begin
                    for (int i = 0; i < 64; i++) pin_mem[i][id] = 1'b0;
                    for (int i = lock_order.size() - 1; i >= 0; i--)
                        if (lock_order[i] == id) lock_order.delete(i);
                    slot_state[id] = RS_FREE;
                    r.region = id;
                end
            end
            OP_CANCEL:
            begin
                lock_order.delete();
                for (int i = 0; i < 16; i++) slot_state[i] = RS_FREE;
                empty_cache();
            end
            OP_TICK:
            begin
                if (lock_order.size() == 0)
                    r.status = STS_NONE;
                else
                begin
                    h = lock_order[0];
                    beg = slot_start[h] >> 23;
                    span = cluster_span(slot_start[h], slot_len[h]);
                    cl = 32'(beg + slot_done[h]);
                    e = cl % ec;
                    r.region = 4'(h);
                    if (slot_state[h] == RS_ALLOC) slot_state[h] = RS_LOCKING;
                    if ((!tag_ok[e] || tag_mem[e] != cl) && pin_mem[e] != 0)
                        r.status = STS_CONFLICT;
                    else
                    begin
                        if (!tag_ok[e] || tag_mem[e] != cl)
                        begin
                            r.fill = 1'b1;
                            r.fill_cl = cl[25:0];
                            r.fill_ent = 6'(e);
                            tag_mem[e] = cl;
                            tag_ok[e] = 1'b1;
                        end
                        pin_mem[e][h] = 1'b1;
                        slot_done[h]++;
                        if (slot_done[h] >= span)
                        begin
                            b = beg[31:0] % ec;
                            if (b + span > ec) r.wrap = 6'(b + span - ec);
                            r.locked = 1'b1;
                            slot_state[h] = RS_LOCKED;
                            void'(lock_order.pop_front());
                        end
                    end
                end
            end
            OP_GET:
            begin
                if (slot_state[id] == RS_FREE)
                    r.status = STS_FREE;
                else if (slot_state[id] != RS_LOCKED)
                begin
                    r.status = STS_NOT_LOCK;
                    r.region = id;
                end
                else
                begin
                    b = (slot_start[id] >> 23) % ec;
                    r.region = id;
                    r.addr = 29'((b << 23) + slot_start[id][22:0]);
                end
            end
            OP_CLEAR:
            begin
                if (lock_order.size() != 0) r.status = STS_BUSY;
                else empty_cache();
            end
            default: ;
        endcase
        r.pend = 5'(lock_order.size());
        return r;
    endfunction

    // one command transfer; start stays high on return unless a random gap was inserted
    task automatic issue_command(opcode_t op, logic [47:0] off, logic [31:0] size,
                                 logic [3:0] id, bit typed, cache_result_t typed_res);
        cache_result_t r;
        start <= 1'b1;
        opcode <= op;
        byte_offset <= off;
        byte_size <= size;
        region_id <= id;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = predict_command(op, off, size, id);
        pending_results.push_back(typed ? typed_res : r);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // drain, then write the entry count while idle
    task automatic set_entry_count(logic [6:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        entries_reg = value;
    endtask

    // result checking at each done strobe
    always @(posedge clk)
    begin
        cache_result_t got, want;
        if (rst_n && done)
        begin
            got = {status, region_out, fill_request, fill_cluster, fill_entry,
                   data_address, region_locked, wrap_clusters, pending_count};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        cmd_row_t      rows [$];
        cache_result_t t;
        int unsigned   ec, pick, clus;
        logic [47:0]   off;
        logic [31:0]   size;
        logic [6:0]    phase_counts [7];

        mismatches = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_LOCK;
        byte_offset = '0;
        byte_size = '0;
        region_id = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        entries_reg = 7'd64;
        for (int i = 0; i < 16; i++) slot_state[i] = RS_FREE;
        empty_cache();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed commands
        rows = '{
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 1, STS_NONE, 5'd0},
            '{OP_LOCK,   48'd0, 32'd0, 4'd0, 1, STS_BAD_SIZE, 5'd0},
            '{OP_GET,    48'd0, 32'd0, 4'd0, 1, STS_FREE, 5'd0},
            '{OP_UNLOCK, 48'd0, 32'd0, 4'd15, 1, STS_FREE, 5'd0},
            '{OP_RSVD6,  48'd0, 32'd0, 4'd0, 1, STS_OK, 5'd0},
            '{OP_RSVD7,  '1,    '1,    4'd15, 1, STS_OK, 5'd0},
            '{OP_LOCK,   48'h7F_FFFF, 32'd2, 4'd0, 0, STS_OK, 5'd0},
            '{OP_LOCK,   '1,    '1,    4'd0, 1, STS_BAD_SIZE, 5'd1},
            '{OP_CLEAR,  48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_GET,    48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_GET,    48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_LOCK,   48'd64 << 23, 32'd1, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_UNLOCK, 48'd0, 32'd0, 4'd1, 0, STS_OK, 5'd0},
            '{OP_UNLOCK, 48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_LOCK,   (48'd63 << 23) + 48'h1234, 32'd3 << 23, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_GET,    48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_CANCEL, 48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_CLEAR,  48'd0, 32'd0, 4'd0, 0, STS_OK, 5'd0},
            '{OP_TICK,   48'd0, 32'd0, 4'd0, 1, STS_NONE, 5'd0}
        };
        foreach (rows[i])
        begin
            t = '0;
            t.status = rows[i].st;
            t.pend = rows[i].pend;
            issue_command(rows[i].op, rows[i].off, rows[i].size, rows[i].id,
                          rows[i].typed, t);
        end

        // random phases, each under its own entry count
        phase_counts = '{7'd1, 7'd127, 7'd0, 7'd20, 7'($urandom_range(2, 63)), 7'd64, 7'd9};
        for (int ph = 0; ph < 7; ph++)
        begin
            set_entry_count(phase_counts[ph]);
            gaps_on = (ph < 6);
            ec = entries_in_use();
            for (int n = 0; n < 118; n++)
            begin
                pick = $urandom_range(0, 99);
                off = 48'({$urandom, $urandom});
                size = $urandom;
                if (pick < 30)
                begin
                    clus = $urandom_range(0, 150);
                    if ($urandom_range(0, 9) != 0)
                        off = {clus[24:0], off[22:0]};
                    if ($urandom_range(0, 19) == 0)
                        size = 32'd0;
                    else if ($urandom_range(0, 9) != 0)
                        size = $urandom_range(1, ec << 23);
                    issue_command(OP_LOCK, off, size, 4'($urandom), 0, '0);
                end
                else if (pick < 70)
                    issue_command(OP_TICK, off, size, 4'($urandom), 0, '0);
                else if (pick < 80)
                    issue_command(OP_UNLOCK, off, size, 4'($urandom), 0, '0);
                else if (pick < 90)
                    issue_command(OP_GET, off, size, 4'($urandom), 0, '0);
                else if (pick < 93)
                    issue_command(OP_CANCEL, off, size, 4'($urandom), 0, '0);
                else if (pick < 97)
                    issue_command(OP_CLEAR, off, size, 4'($urandom), 0, '0);
                else
                    issue_command($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7,
                                  off, size, 4'($urandom), 0, '0);
            end
        end

        // wind down
        start <= 1'b0;
        @(posedge clk);
        for (int w = 0; w < 200000 && pending_results.size() != 0; w++) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
